FILE: sv/irc_message_tokenizer_core_assert.svh
// Assertion macros used by the tokenizer RTL.
`ifndef IRC_MESSAGE_TOKENIZER_CORE_ASSERT_SVH
`define IRC_MESSAGE_TOKENIZER_CORE_ASSERT_SVH

// Condition that holds on every clock edge out of reset.
`define IRC_TOK_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("irc_tok: check failed");

// Same-cycle implication.
`define IRC_TOK_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("irc_tok: check failed");

// Next-cycle implication.
`define IRC_TOK_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("irc_tok: check failed");

`endif

FILE: sv/irc_tok_pkg.sv
// Types and constants of the IRC message tokenizer.
package irc_tok_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PREFIX = 3'd1,
    MODE_SEP    = 3'd2,
    MODE_WORD   = 3'd3,
    MODE_TRAIL  = 3'd4
  } mode_t;

  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_TRAIL  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam int TOTAL_MAX = 63;

  // Line state other than the word counter.
  typedef struct packed {
    mode_t mode;
    logic  colon_seen;
    logic  overflow_seen;
  } state_t;

  // One result item.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] out_char;
    logic [1:0] token_kind;
    logic [4:0] word_index;
    logic       token_start;
    logic       line_end;
    logic       line_error;
    logic [5:0] word_total;
    logic       colon_flag;
    logic       word_overflow;
  } result_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      return c - CASE_DIFF;
    end
    return c;
  endfunction

endpackage

FILE: sv/irc_tok_step.sv
// Per-character tokenizer step: next line state and the result item.
module irc_tok_step import irc_tok_pkg::*; #(
  parameter int MAX_WORDS = 32,
  parameter int CNT_W     = 6
) (
  input  logic [7:0]       ch,
  input  state_t           st,
  input  logic [CNT_W-1:0] cnt,
  output state_t           st_next,
  output logic [CNT_W-1:0] cnt_next,
  output result_t          res
);

  localparam int IDX_LIM = (MAX_WORDS - 1 < 31) ? MAX_WORDS - 1 : 31;

  mode_t            mode;
  logic             bw_full;
  logic [CNT_W-1:0] cnt_bw;
  logic [CNT_W-1:0] idx_cur_raw;
  logic [CNT_W-1:0] idx_new_raw;
  logic [4:0]       idx_cur;
  logic [4:0]       idx_new;
  logic [5:0]       total;

  // Codes with no meaning act as line start.
  assign mode = (st.mode > MODE_TRAIL) ? MODE_START : st.mode;

  // Word count after opening a new word.
  assign bw_full = (32'(cnt) >= 32'(MAX_WORDS));
  assign cnt_bw  = bw_full ? CNT_W'(MAX_WORDS) : cnt + CNT_W'(1);

  assign idx_cur_raw = (cnt == '0) ? '0 : cnt - CNT_W'(1);
  assign idx_new_raw = cnt_bw - CNT_W'(1);
  assign idx_cur = (32'(idx_cur_raw) > 32'(IDX_LIM)) ? 5'(IDX_LIM) : 5'(idx_cur_raw);
  assign idx_new = (32'(idx_new_raw) > 32'(IDX_LIM)) ? 5'(IDX_LIM) : 5'(idx_new_raw);

  assign total = (32'(cnt) > 32'(TOTAL_MAX)) ? 6'(TOTAL_MAX) : 6'(cnt);

  always_comb begin
    st_next  = st;
    st_next.mode = mode;
    cnt_next = cnt;
    res      = '0;

    if (ch == CHAR_NUL) begin
      res.line_end   = 1'b1;
      res.line_error = (mode == MODE_PREFIX);
      res.word_total = (mode == MODE_PREFIX) ? 6'd0 : total;
      res.colon_flag = (mode == MODE_PREFIX) ? 1'b0 : st.colon_seen;
      st_next.mode          = MODE_START;
      st_next.colon_seen    = 1'b0;
      st_next.overflow_seen = 1'b0;
      cnt_next              = '0;
    end else if (mode == MODE_START && ch == CHAR_COLON) begin
      st_next.mode    = MODE_PREFIX;
      res.token_start = 1'b1;
      res.token_kind  = KIND_PREFIX;
    end else if (mode == MODE_PREFIX) begin
      if (ch == CHAR_SPACE) begin
        st_next.mode = MODE_SEP;
      end else begin
        res.data_valid = 1'b1;
        res.out_char   = ch;
        res.token_kind = KIND_PREFIX;
      end
    end else if (mode == MODE_WORD) begin
      if (ch == CHAR_SPACE) begin
        st_next.mode = MODE_SEP;
      end else begin
        res.data_valid = 1'b1;
        res.out_char   = (cnt == CNT_W'(1)) ? to_upper(ch) : ch;
        res.token_kind = KIND_WORD;
        res.word_index = idx_cur;
      end
    end else if (mode == MODE_TRAIL) begin
      res.data_valid = 1'b1;
      res.out_char   = (cnt == CNT_W'(1)) ? to_upper(ch) : ch;
      res.token_kind = KIND_TRAIL;
      res.word_index = idx_cur;
    end else begin
      // line start without prefix, or between words
      if (ch == CHAR_SPACE) begin
        st_next.mode = MODE_SEP;
      end else begin
        cnt_next = cnt_bw;
        if (bw_full) begin
          st_next.overflow_seen = 1'b1;
        end
        res.token_start = 1'b1;
        res.word_index  = idx_new;
        if (ch == CHAR_COLON) begin
          st_next.colon_seen = 1'b1;
          st_next.mode       = MODE_TRAIL;
          res.token_kind     = KIND_TRAIL;
        end else begin
          st_next.mode   = MODE_WORD;
          res.data_valid = 1'b1;
          res.out_char   = (cnt_bw == CNT_W'(1)) ? to_upper(ch) : ch;
          res.token_kind = KIND_WORD;
        end
      end
    end

    // Overflow is reported on every item, from the state before a line end.
    res.word_overflow = (ch == CHAR_NUL) ? st.overflow_seen : st_next.overflow_seen;
  end

endmodule

FILE: sv/irc_message_tokenizer_core.sv
// Top level of the IRC message tokenizer: input register, step logic, result register.
// Usage:
//   Input channel (in_valid / in_stall / ch) carries one character of an IRC
//   message line per item; a zero byte terminates the line, no CR LF.
//   Output channel (out_valid / out_stall / fields) returns exactly one result
//   item per input item, in order: the character tagged with token kind,
//   word index and token start mark; at the terminator, the line summary
//   (word_total, colon_flag, line_error); word_overflow comes with every item.
// Path: an accepted item lands in the input register, then passes through the step
//   logic into the result register, which drives out_valid.
// Throughput: 1 item per cycle while out_stall is low; the only loop is the line
//   state register (mode, word counter, flags), updated in the same cycle the result
//   is written.
// Reset (rst, synchronous): both registers empty, line state back to line
//   start with zero words.
// Stall: while out_stall holds a full result register, the input register
//   keeps its item and in_stall rises only once that register is also full;
//   one held item plus one held result are absorbed without loss.
// MAX_WORDS (2..64): words counted per line; index and total saturate.
`include "irc_message_tokenizer_core_assert.svh"

module irc_message_tokenizer_core import irc_tok_pkg::*; #(
  parameter int MAX_WORDS = 32
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       data_valid,
  output logic [7:0] out_char,
  output logic [1:0] token_kind,
  output logic [4:0] word_index,
  output logic       token_start,
  output logic       line_end,
  output logic       line_error,
  output logic [5:0] word_total,
  output logic       colon_flag,
  output logic       word_overflow
);

  localparam int CNT_W   = $clog2(MAX_WORDS + 1);
  localparam int IDX_LIM = (MAX_WORDS - 1 < 31) ? MAX_WORDS - 1 : 31;

  // input register
  logic       in_full;
  logic [7:0] ch_q;

  // line state
  state_t           st;
  state_t           st_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // result register
  result_t res_next;
  result_t res_q;
  logic    out_full;

  logic out_free;
  logic advance;

  assign out_free = !out_full || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      ch_q <= ch;
    end
  end

  irc_tok_step #(
    .MAX_WORDS (MAX_WORDS),
    .CNT_W     (CNT_W)
  ) u_step (
    .ch       (ch_q),
    .st       (st),
    .cnt      (cnt),
    .st_next  (st_next),
    .cnt_next (cnt_next),
    .res      (res_next)
  );

  // Line state advances only when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= MODE_START;
      st.colon_seen    <= 1'b0;
      st.overflow_seen <= 1'b0;
      cnt              <= '0;
    end else if (advance) begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_free) begin
      out_full <= in_full;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign out_valid     = out_full;
  assign data_valid    = res_q.data_valid;
  assign out_char      = res_q.out_char;
  assign token_kind    = res_q.token_kind;
  assign word_index    = res_q.word_index;
  assign token_start   = res_q.token_start;
  assign line_end      = res_q.line_end;
  assign line_error    = res_q.line_error;
  assign word_total    = res_q.word_total;
  assign colon_flag    = res_q.colon_flag;
  assign word_overflow = res_q.word_overflow;

  // A terminator leaves the line state at line start with no words.
  `IRC_TOK_ASSERT_NEXT(a_line_reset, advance && (ch_q == CHAR_NUL),
    (st.mode == MODE_START) && (cnt == '0) && !st.colon_seen && !st.overflow_seen)
  // The terminator item carries no token character.
  `IRC_TOK_ASSERT_IMP(a_end_no_data, out_valid && line_end, !data_valid && !token_start)
  // Word index saturates at the configured limit.
  `IRC_TOK_ASSERT_IMP(a_index_limit, out_valid, 32'(word_index) <= 32'(IDX_LIM))
  // Word counter never passes MAX_WORDS.
  `IRC_TOK_ASSERT_ALWAYS(a_count_limit, 32'(cnt) <= 32'(MAX_WORDS))
  // Line error only at line end.
  `IRC_TOK_ASSERT_IMP(a_error_at_end, out_valid && line_error, line_end)

endmodule
